@@ design/dewt_pkg.sv @@
// Package for the deadline and event wait table: payload structs, command
// and status codes, sizes, and the front-to-back request word. No dependencies.
`default_nettype none
package dewt_pkg;
    // Table size and field widths; the payload structs are built from these.
    localparam int TABLE_DEPTH = 16;
    localparam int TIME_WIDTH = 48;
    localparam int ID_WIDTH = 32;

    localparam int CmdW = 3;
    localparam int FieldTimeW = TIME_WIDTH;
    localparam int FieldIdW = ID_WIDTH;
    localparam int CountW = $clog2(TABLE_DEPTH + 1);

    localparam logic [CmdW-1:0] CMD_ARM_DEADLINE = 3'd0;
    localparam logic [CmdW-1:0] CMD_ARM_EXTERNAL = 3'd1;
    localparam logic [CmdW-1:0] CMD_DROP         = 3'd2;
    localparam logic [CmdW-1:0] CMD_COMPLETE     = 3'd3;
    localparam logic [CmdW-1:0] CMD_TAKE         = 3'd4;
    localparam logic [CmdW-1:0] CMD_NEXT         = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    typedef struct packed {
        logic [CmdW-1:0]       command;
        logic [FieldTimeW-1:0] now_ms;
        logic [FieldTimeW-1:0] delay_ms;
        logic [FieldIdW-1:0]   target_id;
    } in_word_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [FieldIdW-1:0]   wait_id;
        logic                  has_deadline;
        logic [FieldTimeW-1:0] time_left_ms;
        logic [CountW-1:0]     pending_count;
    } out_word_t;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic [CmdW-1:0]       command;
        logic [FieldTimeW-1:0] now_ms;
        logic [FieldTimeW-1:0] due_ms;
        logic [FieldIdW-1:0]   target_id;
    } req_t;
endpackage
`default_nettype wire

@@ design/dewt_front.sv @@
// Front end: masks fields, computes the saturated due time and queues requests.
// Depends on dewt_pkg.
`default_nettype none
module dewt_front
    import dewt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_word_t in_word,
    input  wire logic     in_valid,
    output logic          in_ready,
    output req_t          req,
    output logic          req_valid,
    input  wire logic     req_ready
);
    localparam logic [FieldTimeW-1:0] TMask = FieldTimeW'((65'd1 << TIME_WIDTH) - 65'd1);
    localparam logic [FieldIdW-1:0] IMask = FieldIdW'((65'd1 << ID_WIDTH) - 65'd1);

    // two-entry queue
    req_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    req_t       enq;
    logic [FieldTimeW:0] sum;
    logic       push, pop;

    always_comb
    begin
        enq.command = in_word.command;
        enq.now_ms = in_word.now_ms & TMask;
        enq.target_id = in_word.target_id & IMask;
        sum = {1'b0, in_word.now_ms & TMask} + {1'b0, in_word.delay_ms & TMask};
        if (sum > {1'b0, TMask})
            enq.due_ms = TMask;
        else
            enq.due_ms = sum[FieldTimeW-1:0];
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign req_valid = (cnt_reg != 2'd0);
    assign pop = req_valid && req_ready;
    assign req = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= enq;
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_pop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> cnt_reg == $past(cnt_reg) - 2'd1) else $error("count");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad count");
`endif
endmodule
`default_nettype wire

@@ design/dewt_back.sv @@
// Back end: the wait table and a sequencer that scans it one entry per cycle.
// Depends on dewt_pkg.
`default_nettype none
module dewt_back
    import dewt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req,
    input  wire logic req_valid,
    output logic      req_ready,
    output out_word_t out_word,
    output logic      out_valid,
    input  wire logic out_ready
);
    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CntW-1:0] Depth = CntW'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [ID_WIDTH-1:0]   id_mem [TABLE_DEPTH];
    logic [TIME_WIDTH-1:0] due_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] timed_reg;
    logic [TABLE_DEPTH-1:0] ready_reg;

    logic [2:0]            state_reg;
    logic [CntW-1:0]       count_reg;
    logic [ID_WIDTH-1:0]   next_id_reg;
    req_t                  cur_reg;
    logic [CntW-1:0]       idx_reg;
    logic [IdxW-1:0]       hit_reg;
    logic [1:0]            st_reg;
    logic [ID_WIDTH-1:0]   wid_reg;
    logic                  has_reg;
    logic [TIME_WIDTH-1:0] left_reg;
    logic                  ov_reg;

    logic [IdxW-1:0]       i;
    logic [IdxW-1:0]       last;
    logic [TIME_WIDTH-1:0] e_due, now_t, l_val;
    logic [ID_WIDTH-1:0]   e_id, tgt;
    logic                  due_hit;
    logic [ID_WIDTH-1:0]   inc_id;

    assign i = idx_reg[IdxW-1:0];
    assign last = IdxW'(count_reg - CntW'(1));
    assign e_due = due_mem[i];
    assign e_id = id_mem[i];
    assign now_t = cur_reg.now_ms[TIME_WIDTH-1:0];
    assign tgt = cur_reg.target_id[ID_WIDTH-1:0];
    assign due_hit = ready_reg[i] || (timed_reg[i] && e_due <= now_t);
    assign l_val = (e_due > now_t) ? e_due - now_t : '0;
    assign inc_id = (next_id_reg + ID_WIDTH'(1) == '0) ? ID_WIDTH'(1)
                                                       : next_id_reg + ID_WIDTH'(1);

    assign req_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    always_comb
    begin
        out_word.status = st_reg;
        out_word.wait_id = FieldIdW'(wid_reg);
        out_word.has_deadline = has_reg;
        out_word.time_left_ms = FieldTimeW'(left_reg);
        out_word.pending_count = CountW'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            next_id_reg <= ID_WIDTH'(1);
            ov_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && !ov_reg)
                    begin
                        idx_reg <= '0;
                        st_reg <= ST_OK;
                        wid_reg <= '0;
                        has_reg <= 1'b0;
                        left_reg <= '0;
                        if (req.command == CMD_ARM_DEADLINE ||
                            req.command == CMD_ARM_EXTERNAL)
                        begin
                            if (count_reg >= Depth)
                                st_reg <= ST_FULL;
                            else
                            begin
                                wid_reg <= next_id_reg;
                                next_id_reg <= inc_id;
                                count_reg <= count_reg + CntW'(1);
                            end
                            state_reg <= S_DONE;
                        end
                        else if (req.command inside {CMD_DROP, CMD_COMPLETE, CMD_TAKE,
                                                     CMD_NEXT})
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        // end of table: no hit
                        if (cur_reg.command == CMD_DROP || cur_reg.command == CMD_COMPLETE)
                            st_reg <= ST_NOT_FOUND;
                        else if (cur_reg.command == CMD_TAKE)
                            st_reg <= ST_NONE;
                        else
                            st_reg <= has_reg ? ST_OK : ST_NONE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CntW'(1);
                        case (cur_reg.command)
                            CMD_DROP, CMD_COMPLETE:
                            begin
                                if (e_id == tgt)
                                begin
                                    wid_reg <= tgt;
                                    hit_reg <= i;
                                    state_reg <= (cur_reg.command == CMD_DROP) ? S_MOVE
                                                                              : S_DONE;
                                end
                            end
                            CMD_TAKE:
                            begin
                                if (due_hit)
                                begin
                                    wid_reg <= e_id;
                                    hit_reg <= i;
                                    state_reg <= S_MOVE;
                                end
                            end
                            default:
                            begin
                                if (timed_reg[i])
                                begin
                                    if (!has_reg || l_val < left_reg)
                                        left_reg <= l_val;
                                    has_reg <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_MOVE:
                begin
                    count_reg <= count_reg - CntW'(1);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // table storage and payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid && !ov_reg)
        begin
            cur_reg <= req;
            if ((req.command == CMD_ARM_DEADLINE || req.command == CMD_ARM_EXTERNAL)
                && count_reg < Depth)
            begin
                id_mem[IdxW'(count_reg)] <= next_id_reg;
                due_mem[IdxW'(count_reg)] <= (req.command == CMD_ARM_DEADLINE)
                    ? req.due_ms[TIME_WIDTH-1:0] : '0;
            end
        end
        if (state_reg == S_MOVE)
        begin
            id_mem[hit_reg] <= id_mem[last];
            due_mem[hit_reg] <= due_mem[last];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timed_reg <= '0;
            ready_reg <= '0;
        end
        else if (state_reg == S_IDLE && req_valid && !ov_reg &&
                 (req.command == CMD_ARM_DEADLINE || req.command == CMD_ARM_EXTERNAL)
                 && count_reg < Depth)
        begin
            timed_reg[IdxW'(count_reg)] <= (req.command == CMD_ARM_DEADLINE);
            ready_reg[IdxW'(count_reg)] <= 1'b0;
        end
        else if (state_reg == S_SCAN && idx_reg < count_reg &&
                 cur_reg.command == CMD_COMPLETE && e_id == tgt)
            ready_reg[i] <= 1'b1;
        else if (state_reg == S_MOVE)
        begin
            timed_reg[hit_reg] <= timed_reg[last];
            ready_reg[hit_reg] <= ready_reg[last];
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Depth) else $error("count over depth");
    a_id_nz: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0) else $error("zero id");
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MOVE |=> count_reg == $past(count_reg) - CntW'(1))
        else $error("remove count");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg && $stable(st_reg) && $stable(wid_reg))
        else $error("result lost");
`endif
endmodule
`default_nettype wire

@@ design/deadline_and_event_wait_table.sv @@
// Deadline and event wait table: top level joining the front queue to the back.
// Depends on dewt_pkg, dewt_front, dewt_back.
//
// Arm commands go from idle straight to the done state, while drop,
// complete, take and next walk the table one entry per cycle in the back
// sequencer before the done state. A two-word queue
// lets new words be accepted while the back scans, and the result register
// holds a finished word until it is taken. Ids start at 1, skip 0 on wrap;
// a full table answers id 0 with status full. Table depth and field widths
// are fixed in dewt_pkg. No clearing pass after reset.
`default_nettype none
module deadline_and_event_wait_table
    import dewt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  in_word,
    input  wire logic      in_valid,
    output logic           in_ready,
    output out_word_t      out_word,
    output logic           out_valid,
    input  wire logic      out_ready
);
    req_t req;
    logic req_valid, req_ready;

    // hold classified words between the two halves
    dewt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_ready(in_ready), .req(req), .req_valid(req_valid), .req_ready(req_ready)
    );

    // advance the table scan and drive the result register
    dewt_back u_back (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_ready(req_ready), .out_word(out_word), .out_valid(out_valid),
        .out_ready(out_ready)
    );
endmodule
`default_nettype wire

@@ dv/tb_deadline_and_event_wait_table.sv @@
// Self-checking bench for the deadline and event wait table: directed table, then random words.
// Depends on dewt_pkg and deadline_and_event_wait_table.
`default_nettype none
module tb_deadline_and_event_wait_table;
    import dewt_pkg::*;

    localparam int Depth = 16;
    localparam int NumRandom = 1600;
    localparam int WatchLimit = 20000;
    localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;
    localparam logic [CmdW-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CmdW-1:0] CMD_SPARE_HI = 3'd7;

    logic      clk;
    logic      rst_n;
    in_word_t  in_word;
    logic      in_valid;
    logic      in_ready;
    out_word_t out_word;
    logic      out_valid;
    logic      out_ready;

    deadline_and_event_wait_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_word(in_word), .in_valid(in_valid), .in_ready(in_ready),
        .out_word(out_word), .out_valid(out_valid), .out_ready(out_ready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the wait table.
    logic [31:0] sh_id [Depth];
    logic [47:0] sh_due [Depth];
    logic        sh_timed [Depth];
    logic        sh_ready [Depth];
    int          sh_count;
    logic [31:0] sh_next_id;

    out_word_t expected_words [$];
    int        fail_count = 0;
    int        mismatch_count = 0;
    int        table_errs;
    int        idle_cycles = 0;
    bit        calm;

    // Drop slot i, filling the hole with the last entry.
    function automatic void pull_slot(int i);
        int last;
        last = sh_count - 1;
        sh_id[i] = sh_id[last];
        sh_due[i] = sh_due[last];
        sh_timed[i] = sh_timed[last];
        sh_ready[i] = sh_ready[last];
        sh_count = last;
    endfunction

    // Advance the shadow table by one word and return the answer it gives.
    function automatic out_word_t predict_wait_table(in_word_t w);
        out_word_t r;
        logic [48:0] sum;
        logic [47:0] left;
        int hit;
        r = '0;
        hit = -1;
        case (w.command)
            CMD_ARM_DEADLINE, CMD_ARM_EXTERNAL:
            begin
                if (sh_count >= Depth)
                    r.status = ST_FULL;
                else
                begin
                    sum = {1'b0, w.now_ms} + {1'b0, w.delay_ms};
                    sh_id[sh_count] = sh_next_id;
                    sh_timed[sh_count] = (w.command == CMD_ARM_DEADLINE);
                    sh_due[sh_count] = (w.command != CMD_ARM_DEADLINE) ? 48'd0 :
                                       sum[48] ? TimeMax : sum[47:0];
                    sh_ready[sh_count] = 1'b0;
                    sh_count++;
                    r.wait_id = sh_next_id;
                    sh_next_id = sh_next_id + 32'd1;
                    if (sh_next_id == 32'd0)
                        sh_next_id = 32'd1;
                end
            end
            CMD_DROP, CMD_COMPLETE:
            begin
                for (int i = 0; i < sh_count; i++)
                    if (hit < 0 && sh_id[i] == w.target_id)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.wait_id = w.target_id;
                    if (w.command == CMD_DROP)
                        pull_slot(hit);
                    else
                        sh_ready[hit] = 1'b1;
                end
            end
            CMD_TAKE:
            begin
                r.status = ST_NONE;
                for (int i = 0; i < sh_count; i++)
                    if (hit < 0 && (sh_ready[i] || (sh_timed[i] && sh_due[i] <= w.now_ms)))
                        hit = i;
                if (hit >= 0)
                begin
                    r.status = ST_OK;
                    r.wait_id = sh_id[hit];
                    pull_slot(hit);
                end
            end
            CMD_NEXT:
            begin
                for (int i = 0; i < sh_count; i++)
                    if (sh_timed[i])
                    begin
                        left = (sh_due[i] > w.now_ms) ? sh_due[i] - w.now_ms : 48'd0;
                        if (!r.has_deadline || left < r.time_left_ms)
                            r.time_left_ms = left;
                        r.has_deadline = 1'b1;
                    end
                r.status = r.has_deadline ? ST_OK : ST_NONE;
            end
            default: ;
        endcase
        r.pending_count = sh_count[CountW-1:0];
        return r;
    endfunction

    // Predict without disturbing the shadow table.
    function automatic out_word_t predict_wait_table_peek(in_word_t w);
        logic [31:0] s_id [Depth];
        logic [47:0] s_due [Depth];
        logic        s_timed [Depth];
        logic        s_ready [Depth];
        int          s_count;
        logic [31:0] s_next;
        out_word_t   r;
        s_id = sh_id;
        s_due = sh_due;
        s_timed = sh_timed;
        s_ready = sh_ready;
        s_count = sh_count;
        s_next = sh_next_id;
        r = predict_wait_table(w);
        sh_id = s_id;
        sh_due = s_due;
        sh_timed = s_timed;
        sh_ready = s_ready;
        sh_count = s_count;
        sh_next_id = s_next;
        return r;
    endfunction

    // Directed rows; check_fixed rows also compare against a typed-in answer.
    typedef struct {
        in_word_t  w;
        bit        check_fixed;
        out_word_t fixed;
    } row_t;

    row_t rows [$];

    function automatic in_word_t mk(logic [2:0] c, logic [47:0] n, logic [47:0] d,
                                    logic [31:0] t);
        in_word_t w;
        w.command = c;
        w.now_ms = n;
        w.delay_ms = d;
        w.target_id = t;
        return w;
    endfunction

    function automatic out_word_t ans(logic [1:0] s, logic [31:0] id, logic h,
                                      logic [47:0] l, logic [4:0] p);
        out_word_t r;
        r.status = s;
        r.wait_id = id;
        r.has_deadline = h;
        r.time_left_ms = l;
        r.pending_count = p;
        return r;
    endfunction

    function automatic void add_row(in_word_t w, bit chk, out_word_t f);
        row_t r;
        r.w = w;
        r.check_fixed = chk;
        r.fixed = f;
        rows.push_back(r);
    endfunction

    // Hold one word on the input until it is taken; random gaps before it.
    task automatic send_word(in_word_t w);
        out_word_t p;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = predict_wait_table(w);
        expected_words.push_back(p);
    endtask

    function automatic logic [31:0] pick_target();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7 && sh_count > 0)
            return sh_id[$urandom_range(0, sh_count - 1)];
        if (k == 7)
            return $urandom;
        return sh_next_id - $urandom_range(1, 4);
    endfunction

    // Sink side: random stall bursts, compare each accepted word with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (mismatch_count++ < 10)
                        $display("unexpected result word %p", out_word);
                end
                else
                begin
                    out_word_t e;
                    e = expected_words.pop_front();
                    if (out_word !== e)
                    begin
                        fail_count++;
                        if (mismatch_count++ < 10)
                            $display("mismatch: expected %p actual %p", e, out_word);
                    end
                end
            end
            if (calm)
                out_ready <= 1'b1;
            else if (out_ready && $urandom_range(0, 5) == 0)
                out_ready <= 1'b0;
            else if (!out_ready && $urandom_range(0, 2) == 0)
                out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        in_word_t w;
        int k;
        logic [2:0] c;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        table_errs = 0;
        calm = 0;
        sh_count = 0;
        sh_next_id = 32'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: nothing to take, no deadline, unknown ids, spare codes.
        add_row(mk(CMD_TAKE, 48'd0, 48'd0, 32'd0), 1, ans(ST_NONE, 0, 0, 0, 0));
        add_row(mk(CMD_NEXT, TimeMax, 48'd0, 32'd0), 1, ans(ST_NONE, 0, 0, 0, 0));
        add_row(mk(CMD_DROP, 48'd0, 48'd0, 32'd0), 1, ans(ST_NOT_FOUND, 0, 0, 0, 0));
        add_row(mk(CMD_COMPLETE, 48'd0, 48'd0, '1), 1,
                ans(ST_NOT_FOUND, 0, 0, 0, 0));
        add_row(mk(CMD_SPARE_LO, TimeMax, TimeMax, '1), 1, ans(ST_OK, 0, 0, 0, 0));
        add_row(mk(CMD_SPARE_HI, TimeMax, TimeMax, '1), 1, ans(ST_OK, 0, 0, 0, 0));
        // Saturating due time, then ids 1 and 2.
        add_row(mk(CMD_ARM_DEADLINE, TimeMax, TimeMax, 32'd0), 1, ans(ST_OK, 1, 0, 0, 1));
        add_row(mk(CMD_ARM_EXTERNAL, 48'd5, 48'd5, 32'd0), 1, ans(ST_OK, 2, 0, 0, 2));
        add_row(mk(CMD_NEXT, 48'd0, 48'd0, 32'd0), 1, ans(ST_OK, 0, 1, TimeMax, 2));
        add_row(mk(CMD_TAKE, TimeMax, 48'd0, 32'd0), 1, ans(ST_OK, 1, 0, 0, 1));
        add_row(mk(CMD_COMPLETE, 48'd0, 48'd0, 32'd2), 1, ans(ST_OK, 2, 0, 0, 1));
        add_row(mk(CMD_TAKE, 48'd0, 48'd0, 32'd0), 1, ans(ST_OK, 2, 0, 0, 0));
        // Fill past capacity: the last arm must answer full.
        for (int i = 0; i < 17; i++)
            add_row(mk(i[0] ? CMD_ARM_EXTERNAL : CMD_ARM_DEADLINE, 48'd100,
                       48'(i * 7), 32'd0), 0, '0);
        add_row(mk(CMD_DROP, 48'd0, 48'd0, 32'd3), 0, '0);
        add_row(mk(CMD_NEXT, 48'd200, 48'd0, 32'd0), 0, '0);

        foreach (rows[i])
        begin
            if (rows[i].check_fixed && predict_wait_table_peek(rows[i].w) !== rows[i].fixed)
            begin
                table_errs++;
                $display("directed row %0d: typed answer differs from prediction", i);
            end
            send_word(rows[i].w);
        end

        // Random part: mostly sensible commands on live ids, with noise.
        for (int n = 0; n < NumRandom; n++)
        begin
            if (n > NumRandom - 150)
                calm = 1;
            k = $urandom_range(0, 99);
            if (k < 20)
                c = CMD_ARM_DEADLINE;
            else if (k < 32)
                c = CMD_ARM_EXTERNAL;
            else if (k < 47)
                c = CMD_DROP;
            else if (k < 64)
                c = CMD_COMPLETE;
            else if (k < 84)
                c = CMD_TAKE;
            else if (k < 97)
                c = CMD_NEXT;
            else
                c = 3'($urandom_range(6, 7));
            w.command = c;
            w.now_ms = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) :
                       48'($urandom_range(0, 2000));
            w.delay_ms = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) :
                         48'($urandom_range(0, 1000));
            w.target_id = pick_target();
            send_word(w);
        end
        in_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && table_errs == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
